// File: hdl/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the wheel tick speedometer: field widths,
// register map, scale factor and the state encodings of both controllers.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int TS_W      = 32;
  localparam int CNT_W     = 32;
  localparam int SPD_W     = 20;
  localparam int WHEEL_W   = 12;
  localparam int SCALE     = 360;
  localparam int KW        = 21;
  localparam int DIG       = 4;
  localparam int NDIG      = CNT_W / DIG;
  localparam int NW        = CNT_W + KW;
  localparam int CTR_W     = 5;
  localparam int OUT_W     = 64;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int WINDOW_DEPTH_DEF = 3;
  localparam int TIME_BITS_DEF    = 32;

  localparam logic [WHEEL_W-1:0] WHEEL_RST = 12'd2228;
  localparam logic [0:0]         REG_WHEEL = 1'b0;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_UPD,
    TS_MIN,
    TS_LOAD,
    TS_RUN,
    TS_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_MUL,
    SU_CHK,
    SU_DIV,
    SU_DONE
  } su_state_e;

  typedef enum logic [1:0] {
    SEL_CUR,
    SEL_AVG,
    SEL_MAX
  } spd_sel_e;

endpackage

// File: hdl/wts_speed_unit.sv
// ----------------------------------------------------------------------------
// wts_speed_unit
// Serial speed arithmetic: ticks * scale by 4-bit digits, then a saturation
// check and a restoring division giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wts_speed_unit import wts_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CNT_W-1:0]     ticks_i,
  input  logic [TIME_BITS-1:0] span_i,
  input  logic [KW-1:0]        scale_i,
  output logic                 done_o,
  output logic [SPD_W-1:0]     speed_o
);

  localparam int HW = NW - SPD_W;
  localparam int CW = (HW > TIME_BITS) ? HW : TIME_BITS;
  localparam logic [CTR_W-1:0] MUL_LAST = CTR_W'(NDIG - 1);
  localparam logic [CTR_W-1:0] DIV_LAST = CTR_W'(SPD_W - 1);

  su_state_e              state_q, state_d;
  logic [CTR_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       ticks_q, ticks_d;
  logic [TIME_BITS-1:0]   span_q, span_d;
  logic [KW-1:0]          scale_q, scale_d;
  logic [NW-1:0]          acc_q, acc_d;
  logic [TIME_BITS-1:0]   rem_q, rem_d;
  logic [SPD_W-1:0]       num_q, num_d;
  logic [SPD_W-1:0]       quot_q, quot_d;

  logic [KW+DIG-1:0]      prod;
  logic                   sat;
  logic [TIME_BITS:0]     trial;
  logic [TIME_BITS:0]     trial_diff;
  logic                   trial_ge;

  assign prod       = (KW+DIG)'(scale_q) * (KW+DIG)'(ticks_q[CNT_W-1 -: DIG]);
  assign sat        = CW'(acc_q[NW-1:SPD_W]) >= CW'(span_q);
  assign trial      = {rem_q, num_q[SPD_W-1]};
  assign trial_diff = trial - {1'b0, span_q};
  assign trial_ge   = trial >= {1'b0, span_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SU_IDLE: if (start_i) state_d = SU_MUL;
      SU_MUL:  if (cnt_q == MUL_LAST) state_d = SU_CHK;
      SU_CHK:  state_d = sat ? SU_DONE : SU_DIV;
      SU_DIV:  if (cnt_q == DIV_LAST) state_d = SU_DONE;
      SU_DONE: state_d = SU_IDLE;
      default: state_d = SU_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d   = cnt_q;
    ticks_d = ticks_q;
    span_d  = span_q;
    scale_d = scale_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quot_d  = quot_q;
    unique case (state_q)
      SU_IDLE: begin
        ticks_d = ticks_i;
        span_d  = span_i;
        scale_d = scale_i;
        acc_d   = '0;
        cnt_d   = '0;
      end
      SU_MUL: begin
        acc_d   = (acc_q << DIG) + NW'(prod);
        ticks_d = ticks_q << DIG;
        cnt_d   = cnt_q + CTR_W'(1);
      end
      SU_CHK: begin
        cnt_d = '0;
        num_d = acc_q[SPD_W-1:0];
        rem_d = TIME_BITS'(acc_q[NW-1:SPD_W]);
        if (sat) begin
          quot_d = '1;
        end
      end
      SU_DIV: begin
        rem_d  = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        quot_d = {quot_q[SPD_W-2:0], trial_ge};
        num_d  = num_q << 1;
        cnt_d  = cnt_q + CTR_W'(1);
      end
      SU_DONE: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    done_o  = (state_q == SU_DONE);
    speed_o = quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q <= ticks_d;
    span_q  <= span_d;
    scale_q <= scale_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    quot_q  <= quot_d;
  end

endmodule

// File: hdl/wheel_tick_speedometer.sv
// ----------------------------------------------------------------------------
// wheel_tick_speedometer
// Wheel sensor speedometer: current, average and maximum speed per item.
// ----------------------------------------------------------------------------
// Each item is a tick with a millisecond timestamp (tuser low) or a clear
// command (tuser high), and gives exactly one result item holding three
// speeds in 0.01 km/h, floor(360 * ticks * circumference / span) saturated
// at 20 bits. Each item goes through bookkeeping (an update state for a clear,
// an update and a window state for a tick), then the three speeds in turn
// through one shared serial arithmetic unit: a speed with too few ticks or no
// positive span is written as zero without the unit, a saturated one after the
// multiply and the saturation check, any other after eight 4-bit multiply
// digits, a saturation check and one quotient bit per cycle over 20 bits. Then
// the output register is loaded, once it is empty or being read, and the next
// item is taken. The input is taken only between items; the finished result sits in
// an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module wheel_tick_speedometer import wts_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TS_W-1:0]   s_axis_tdata,   // timestamp_ms
  input  logic              s_axis_tuser,   // func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // current_speed, average_speed, maximum_speed
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

  top_state_e             state_q, state_d;
  spd_sel_e               sel_q;
  logic [WHEEL_W-1:0]     wheel_q;
  logic                   func_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [CNT_W-1:0]       tick_total_q;
  logic                   have_first_q;
  logic [TIME_BITS-1:0]   first_q;
  logic [TIME_BITS-1:0]   last_q;
  logic [TIME_BITS-1:0]   win_q [WINDOW_DEPTH];
  logic [FILL_W-1:0]      fill_q;
  logic [TIME_BITS-1:0]   short_q;
  logic                   short_valid_q;
  logic [TIME_BITS-1:0]   gap_q;
  logic                   gap_pos_q;
  logic [SPD_W-1:0]       cur_q, avg_q, max_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [TIME_BITS:0]     gap_diff;
  logic [TIME_BITS-1:0]   op_a, op_b;
  logic                   cnt_ok;
  logic [CNT_W-1:0]       ticks;
  logic [TIME_BITS:0]     span_diff;
  logic                   span_ok;
  logic                   sel_last;
  logic                   res_we;
  logic [SPD_W-1:0]       res_val;
  logic                   out_load;
  logic                   unit_start;
  logic                   unit_done;
  logic [SPD_W-1:0]       unit_speed;
  logic [KW-1:0]          scale;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_WHEEL) ? APB_DW'(wheel_q) : '0;
  assign scale    = KW'(wheel_q) * KW'(SCALE);
  assign gap_diff = {1'b0, time_q} - {1'b0, last_q};
  assign sel_last = (sel_q == SEL_MAX);

  // operands of the speed being set up
  always_comb begin
    unique case (sel_q)
      SEL_CUR: begin
        op_a   = last_q;
        op_b   = win_q[0];
        cnt_ok = fill_q > FILL_W'(1);
        ticks  = CNT_W'(fill_q - FILL_W'(1));
      end
      SEL_AVG: begin
        op_a   = last_q;
        op_b   = first_q;
        cnt_ok = tick_total_q > CNT_W'(1);
        ticks  = tick_total_q - CNT_W'(1);
      end
      SEL_MAX: begin
        op_a   = short_q;
        op_b   = '0;
        cnt_ok = short_valid_q;
        ticks  = CNT_W'(1);
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        cnt_ok = 1'b0;
        ticks  = '0;
      end
    endcase
  end

  assign span_diff = {1'b0, op_a} - {1'b0, op_b};
  assign span_ok   = cnt_ok && !span_diff[TIME_BITS] && (span_diff[TIME_BITS-1:0] != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: if (in_acc) state_d = TS_UPD;
      TS_UPD:  state_d = func_q ? TS_LOAD : TS_MIN;
      TS_MIN:  state_d = TS_LOAD;
      TS_LOAD: begin
        if (span_ok) state_d = TS_RUN;
        else if (sel_last) state_d = TS_DONE;
      end
      TS_RUN: begin
        if (unit_done) state_d = sel_last ? TS_DONE : TS_LOAD;
      end
      TS_DONE: if (!out_valid_q || m_axis_tready) state_d = TS_IDLE;
      default: state_d = TS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == TS_IDLE);
    unit_start    = (state_q == TS_LOAD) && span_ok;
    res_we        = ((state_q == TS_LOAD) && !span_ok) || ((state_q == TS_RUN) && unit_done);
    res_val       = (state_q == TS_RUN) ? unit_speed : '0;
    out_load      = (state_q == TS_DONE) && (!out_valid_q || m_axis_tready);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= TS_IDLE;
      sel_q         <= SEL_CUR;
      wheel_q       <= WHEEL_RST;
      tick_total_q  <= '0;
      have_first_q  <= 1'b0;
      fill_q        <= '0;
      short_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && (paddr[2] == REG_WHEEL)) begin
        wheel_q <= pwdata[WHEEL_W-1:0];
      end
      if (state_q == TS_UPD) begin
        sel_q <= SEL_CUR;
        if (func_q) begin
          tick_total_q <= '0;
          have_first_q <= 1'b0;
          fill_q       <= '0;
        end
      end else if (res_we && !sel_last) begin
        unique case (sel_q)
          SEL_CUR: sel_q <= SEL_AVG;
          SEL_AVG: sel_q <= SEL_MAX;
          default: sel_q <= SEL_CUR;
        endcase
      end
      if (state_q == TS_MIN) begin
        if (tick_total_q != '1) begin
          tick_total_q <= tick_total_q + CNT_W'(1);
        end
        have_first_q <= 1'b1;
        if (have_first_q && gap_pos_q && (!short_valid_q || (gap_q < short_q))) begin
          short_valid_q <= 1'b1;
        end
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser;
      time_q <= TIME_BITS'(s_axis_tdata);
    end
    if (state_q == TS_UPD) begin
      gap_q     <= gap_diff[TIME_BITS-1:0];
      gap_pos_q <= !gap_diff[TIME_BITS] && (gap_diff[TIME_BITS-1:0] != '0);
    end
    if (state_q == TS_MIN) begin
      last_q <= time_q;
      if (!have_first_q) begin
        first_q <= time_q;
      end
      if (have_first_q && gap_pos_q && (!short_valid_q || (gap_q < short_q))) begin
        short_q <= gap_q;
      end
      if (fill_q != FILL_FULL) begin
        win_q[fill_q[IDX_W-1:0]] <= time_q;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WINDOW_DEPTH-1] <= time_q;
      end
    end
    if (res_we) begin
      unique case (sel_q)
        SEL_CUR: cur_q <= res_val;
        SEL_AVG: avg_q <= res_val;
        SEL_MAX: max_q <= res_val;
        default: max_q <= res_val;
      endcase
    end
    if (out_load) begin
      out_data_q <= OUT_W'({max_q, avg_q, cur_q});
    end
  end

  wts_speed_unit #(
    .TIME_BITS(TIME_BITS)
  ) u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .ticks_i (ticks),
    .span_i  (span_diff[TIME_BITS-1:0]),
    .scale_i (scale),
    .done_o  (unit_done),
    .speed_o (unit_speed)
  );

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == TS_RUN))
    else $error("speed unit finished outside a run");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill beyond depth");

  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_first_q == (tick_total_q != '0))
    else $error("first tick flag disagrees with tick count");

  a_short_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    short_valid_q |-> (short_q != '0))
    else $error("shortest interval is zero");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TS_DONE && out_valid_q && !m_axis_tready) |=> (state_q == TS_DONE))
    else $error("result overwritten while still pending");

endmodule
